### rtl/thr_pkg.sv
// Shared types, constants and helper functions of the handshake receiver.
// Used by every module of the block; depends on nothing else.
package thr_pkg;

	// Default magic prefix length in bytes.
	localparam int HEADER_BYTES_DEF = 26;
	// Default depth of the command queue between front and back end.
	localparam int QUEUE_DEPTH_DEF = 4;
	// Width of the received byte counter, which saturates at its maximum.
	localparam int CNT_W = 5;

	// Connection states as they appear on the link_state field.
	typedef enum logic [2:0] {
		LS_IDLE        = 3'd0,
		LS_AWAIT_SYN   = 3'd1,
		LS_SYN_SENT    = 3'd2,
		LS_SYNACK_SENT = 3'd3,
		LS_OPEN        = 3'd4,
		LS_CLOSED      = 3'd5
	} link_state_t;

	// Verdict codes.
	typedef enum logic [1:0] {
		V_ACCEPT  = 2'd0,
		V_REJECT  = 2'd1,
		V_FORWARD = 2'd2,
		V_STARTED = 2'd3
	} verdict_t;

	// Command from the front end to the back end: an optional packet to
	// transmit followed by one verdict, all tagged with the new state.
	typedef struct packed {
		logic        send;
		logic [31:0] seq;
		verdict_t    verdict;
		link_state_t state;
	} cmd_t;

	// Byte of the magic prefix at a given position.
	function automatic logic [7:0] magic_byte(input logic [4:0] index);
		logic [7:0] b;
		case (index)
			5'd1:    b = 8'hd5;
			5'd3:    b = 8'he9;
			5'd5:    b = 8'hf3;
			5'd7:    b = 8'hc9;
			5'd9:    b = 8'hfc;
			5'd11:   b = 8'heb;
			5'd13:   b = 8'hfb;
			5'd15:   b = 8'hb9;
			5'd17:   b = 8'hab;
			5'd19:   b = 8'hfc;
			5'd21:   b = 8'hec;
			5'd23:   b = 8'hc3;
			default: b = (index < 5'd24 && !index[0]) ? 8'h30 : 8'h00;
		endcase
		return b;
	endfunction

endpackage

### rtl/thr_front.sv
// Front end: accepts input items, checks received packets and runs the
// connection state machine. Depends on thr_pkg.
module thr_front #(
	parameter int HEADER_BYTES = thr_pkg::HEADER_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [39:0]   s_tdata,  // data_byte [7:0], seed [39:8]
	input  logic          s_tlast,
	input  logic          s_tuser,  // req_type
	input  logic          q_full,
	output logic          q_push,
	output thr_pkg::cmd_t q_cmd
);

	localparam logic [thr_pkg::CNT_W-1:0] HDR_LEN = thr_pkg::CNT_W'(HEADER_BYTES);
	localparam logic [thr_pkg::CNT_W-1:0] PKT_LEN = thr_pkg::CNT_W'(HEADER_BYTES + 4);
	localparam logic [thr_pkg::CNT_W-1:0] CNT_MAX = '1;

	logic                      role_server_q;
	thr_pkg::link_state_t      state_q, state_d;
	logic [31:0]               seq_q, seq_d;
	logic [thr_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_new;
	logic                      pm_q, pm_d, pm_new;
	logic [31:0]               rx_q, rx_d, rx_new;
	logic                      accept;
	logic [7:0]                data_byte;
	logic [31:0]               seed;
	logic                      hdr_ok, len_ok;
	logic [31:0]               seq_p1, seq_p2, rx_p1;

	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;
	assign data_byte = s_tdata[7:0];
	assign seed      = s_tdata[39:8];

	// Role register, written by the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_server_q <= 1'b0;
		end else if (cfg_we) begin
			role_server_q <= cfg_wdata;
		end
	end

	// Receive checks for the current byte.
	always_comb begin
		pm_new  = pm_q;
		rx_new  = rx_q;
		cnt_new = (cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		if (cnt_q < HDR_LEN) begin
			if (data_byte != thr_pkg::magic_byte(cnt_q)) pm_new = 1'b0;
		end else if (cnt_q < PKT_LEN) begin
			rx_new = {rx_q[23:0], data_byte};
		end
		hdr_ok = pm_new && (cnt_new >= HDR_LEN);
		len_ok = cnt_new >= PKT_LEN;
		seq_p1 = seq_q + 32'd1;
		seq_p2 = seq_q + 32'd2;
		rx_p1  = rx_new + 32'd1;
	end

	// Connection state and receive state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= thr_pkg::LS_IDLE;
			seq_q   <= '0;
			cnt_q   <= '0;
			pm_q    <= 1'b1;
			rx_q    <= '0;
		end else begin
			state_q <= state_d;
			seq_q   <= seq_d;
			cnt_q   <= cnt_d;
			pm_q    <= pm_d;
			rx_q    <= rx_d;
		end
	end

	// Next state and the command handed to the back end.
	always_comb begin
		state_d       = state_q;
		seq_d         = seq_q;
		cnt_d         = cnt_q;
		pm_d          = pm_q;
		rx_d          = rx_q;
		q_push        = 1'b0;
		q_cmd.send    = 1'b0;
		q_cmd.verdict = thr_pkg::V_REJECT;
		if (accept) begin
			if (!s_tuser) begin
				// Start request: clear receive state and restart.
				q_push        = 1'b1;
				q_cmd.verdict = thr_pkg::V_STARTED;
				cnt_d         = '0;
				pm_d          = 1'b1;
				rx_d          = '0;
				if (role_server_q) begin
					state_d = thr_pkg::LS_AWAIT_SYN;
				end else begin
					seq_d      = seed;
					state_d    = thr_pkg::LS_SYN_SENT;
					q_cmd.send = 1'b1;
				end
			end else if (!s_tlast) begin
				cnt_d = cnt_new;
				pm_d  = pm_new;
				rx_d  = rx_new;
			end else begin
				// Final byte: judge the packet, then clear receive state.
				q_push = 1'b1;
				cnt_d  = '0;
				pm_d   = 1'b1;
				rx_d   = '0;
				unique case (state_q)
					thr_pkg::LS_AWAIT_SYN: begin
						if (hdr_ok && len_ok) begin
							seq_d         = rx_p1;
							state_d       = thr_pkg::LS_SYNACK_SENT;
							q_cmd.send    = 1'b1;
							q_cmd.verdict = thr_pkg::V_ACCEPT;
						end
					end
					thr_pkg::LS_SYN_SENT: begin
						if (hdr_ok && len_ok) begin
							if (seq_p1 == rx_new) begin
								seq_d         = seq_p2;
								state_d       = thr_pkg::LS_OPEN;
								q_cmd.send    = 1'b1;
								q_cmd.verdict = thr_pkg::V_ACCEPT;
							end else begin
								seq_d = seq_p1;
							end
						end
					end
					thr_pkg::LS_SYNACK_SENT: begin
						if (!hdr_ok) begin
							q_cmd.verdict = thr_pkg::V_FORWARD;
						end else if (len_ok) begin
							seq_d = seq_p1;
							if (seq_p1 == rx_new) begin
								state_d       = thr_pkg::LS_OPEN;
								q_cmd.verdict = thr_pkg::V_ACCEPT;
							end
						end
					end
					thr_pkg::LS_OPEN: begin
						q_cmd.verdict = thr_pkg::V_FORWARD;
					end
					default: begin
						q_cmd.verdict = thr_pkg::V_REJECT;
					end
				endcase
			end
		end
		q_cmd.seq   = seq_d;
		q_cmd.state = state_d;
	end

`ifndef SYNTH
	// A start request always leaves the block waiting for or having sent a SYN.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !s_tuser |=> state_q == thr_pkg::LS_AWAIT_SYN ||
			state_q == thr_pkg::LS_SYN_SENT)
		else $error("start request did not restart the connection");
	// Receive state is cleared after every finished packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser && s_tlast |=> cnt_q == '0 && pm_q && rx_q == '0)
		else $error("receive state not cleared after final byte");
`endif

endmodule

### rtl/thr_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on thr_pkg for the command type.
module thr_queue #(
	parameter int DEPTH = thr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  thr_pkg::cmd_t push_cmd,
	input  logic          pop,
	output thr_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	thr_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == FULL_CNT);
	assign head  = mem_q[rd_ptr_q];

	// Entry storage, no reset needed.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTH
	// Neither overflow nor underflow.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("command queue overflow or underflow");
`endif

endmodule

### rtl/thr_back.sv
// Back end: expands each command into its transmitted packet bytes, if any,
// and the verdict item, held in an output register. Depends on thr_pkg.
module thr_back #(
	parameter int HEADER_BYTES = thr_pkg::HEADER_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  thr_pkg::cmd_t q_head,
	output logic          q_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [15:0]   m_tdata,  // verdict [1:0], tx_byte [9:2], link_state [12:10]
	output logic          m_tlast,
	output logic          m_tuser   // out_kind
);

	localparam int PKT_ITEMS = HEADER_BYTES + 4;
	localparam int IDX_W = $clog2(PKT_ITEMS + 1);
	localparam logic [IDX_W-1:0] HDR_IDX  = IDX_W'(HEADER_BYTES);
	localparam logic [IDX_W-1:0] PKT_IDX  = IDX_W'(PKT_ITEMS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PKT_ITEMS - 1);

	logic                 m_tvalid_q;
	logic                 kind_q, last_q;
	thr_pkg::verdict_t    verdict_q;
	logic [7:0]           byte_q;
	thr_pkg::link_state_t state_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 load, is_tx;
	logic [IDX_W-1:0]     seq_off;
	logic [7:0]           seq_byte, tx_byte;

	assign load    = !q_empty && (!m_tvalid_q || m_tready);
	assign is_tx   = q_head.send && (idx_q < PKT_IDX);
	assign q_pop   = load && !is_tx;
	assign seq_off = idx_q - HDR_IDX;

	// Sequence number byte, most significant first.
	always_comb begin
		case (seq_off[1:0])
			2'd0:    seq_byte = q_head.seq[31:24];
			2'd1:    seq_byte = q_head.seq[23:16];
			2'd2:    seq_byte = q_head.seq[15:8];
			default: seq_byte = q_head.seq[7:0];
		endcase
		tx_byte = (idx_q < HDR_IDX) ? thr_pkg::magic_byte(5'(idx_q)) : seq_byte;
	end

	// Item position within the current command and the valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) idx_q <= is_tx ? idx_q + 1'b1 : '0;
			if (load)          m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q    <= is_tx;
			verdict_q <= is_tx ? thr_pkg::V_ACCEPT : q_head.verdict;
			byte_q    <= is_tx ? tx_byte : 8'h00;
			last_q    <= is_tx && (idx_q == LAST_IDX);
			state_q   <= q_head.state;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, state_q, byte_q, verdict_q};
	assign m_tlast  = last_q;
	assign m_tuser  = kind_q;

`ifndef SYNTH
	// Only a transmitted byte can close a packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("tlast on a verdict item");
	// The final packet byte is always followed by the verdict of that command.
	assert property (@(posedge clk) disable iff (!arst_n)
		load && is_tx && idx_q == LAST_IDX |=> idx_q == PKT_IDX)
		else $error("packet expansion lost its position");
`endif

endmodule

### rtl/three_way_handshake_receiver_core.sv
// Top level of the connection handshake receiver.
// Depends on thr_pkg, thr_front, thr_queue and thr_back.

// Three-way handshake engine. The input stream carries start requests
// (s_tuser low, seed in s_tdata[39:8]) and received packet bytes (s_tuser
// high, byte in s_tdata[7:0], s_tlast on the final byte). The front end
// takes one item per cycle whenever its command queue has room; a packet
// byte that is not final yields no result. A start request, or a final
// byte, yields one command. The back end turns a command into up to 31
// result items at one item per cycle, while m_tready is high, from its
// output register: for a client start or an accepted SYN or SYN-ACK, the
// magic prefix and the big-endian sequence number as transmitted bytes
// (m_tuser high), then one verdict item. Input stalls only while the
// QUEUE_DEPTH-entry queue is full, so the transmit expansion sets the
// sustained rate when handshake packets arrive faster than it drains. The
// role register is written through cfg_we and cfg_wdata and is sampled at
// each start request.
module three_way_handshake_receiver_core #(
	parameter int HEADER_BYTES = thr_pkg::HEADER_BYTES_DEF,
	parameter int QUEUE_DEPTH  = thr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,  // role_server
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,    // data_byte [7:0], seed [39:8]
	input  logic        s_tlast,    // last_byte
	input  logic        s_tuser,    // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // verdict [1:0], tx_byte [9:2], link_state [12:10]
	output logic        m_tlast,    // tx_last
	output logic        m_tuser     // out_kind
);

	logic          q_full, q_empty, q_push, q_pop;
	thr_pkg::cmd_t push_cmd, head_cmd;

	// Packet checks and connection state machine.
	thr_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	// Command queue between the two halves.
	thr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(push_cmd),
		.pop     (q_pop),
		.head    (head_cmd),
		.empty   (q_empty),
		.full    (q_full)
	);

	// Transmit expansion and output register.
	thr_back #(.HEADER_BYTES(HEADER_BYTES)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (head_cmd),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule
